// ===== rtl/rbpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpsr_pkg
// Shared types, codes and arithmetic helpers for the point set rotator.
// ----------------------------------------------------------------------------
package rbpsr_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ARC_LEN          = 30;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    // Limit gain of the CORDIC, 1/K in Q30
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

    // Working widths of the rotator datapath
    localparam int CXW = 36;
    localparam int CZW = 34;
    localparam int SATW = 68;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_MODIFY  = 3'd1,
        OP_TICK    = 3'd2,
        OP_SET_POS = 3'd3,
        OP_SET_HDG = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_SCALE_H    = 3'd0,
        REG_SCALE_V    = 3'd1,
        REG_VELOCITY_X = 3'd2,
        REG_VELOCITY_Y = 3'd3,
        REG_SPIN_RATE  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic               collidable_in;
        logic [5:0]         point_index;
        logic [19:0]        time_step;
        logic signed [31:0] heading_in;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         out_index;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic               collidable_out;
        logic signed [31:0] heading_out;
        logic               last;
    } out_item_t;

    // Rounded arctangent of 2^-i in binary angle units
    function automatic logic [29:0] arc_of(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10680862;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            5'd24: a = 30'd41;
            5'd25: a = 30'd20;
            5'd26: a = 30'd10;
            5'd27: a = 30'd5;
            5'd28: a = 30'd3;
            5'd29: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    // Clamp a wide signed value to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [SATW-1:0] v);
        logic [31:0] r;
        if (v > SATW'(64'sh7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -SATW'(64'sh8000_0000)) begin
            r = 32'h8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rbpsr_if.sv =====
// ----------------------------------------------------------------------------
// rbpsr_in_if / rbpsr_out_if
// Valid/ready channels carrying one request or one emitted point.
// ----------------------------------------------------------------------------
interface rbpsr_in_if
    import rbpsr_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbpsr_out_if
    import rbpsr_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rbpsr_cordic.sv =====
// ----------------------------------------------------------------------------
// rbpsr_cordic
// Iterative rotation unit: one CORDIC step per cycle, then gain compensation
// with round half up and saturation to 32 bits.
// ----------------------------------------------------------------------------
module rbpsr_cordic
    import rbpsr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [CXW-1:0] x0,
    input  logic signed [CXW-1:0] y0,
    input  logic signed [CZW-1:0] z0,
    output logic                  done,
    output logic [31:0]           rx,
    output logic [31:0]           ry
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int PW = CXW + 31;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RUN  = 4'b0010,
        C_MUL  = 4'b0100,
        C_FIN  = 4'b1000
    } cst_t;

    cst_t                  st_reg, st_next;
    logic [IW-1:0]         i_reg;
    logic signed [CXW-1:0] x_reg, y_reg;
    logic signed [CZW-1:0] z_reg;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic [31:0]           rx_reg, ry_reg;
    logic                  done_reg;
    logic signed [CXW-1:0] xs, ys;
    logic signed [CZW-1:0] arc;
    logic signed [SATW-1:0] rnd_x, rnd_y;

    // Shifted operands and table angle for the current step, and rounded gain products
    always_comb
    begin
        xs    = x_reg >>> i_reg;
        ys    = y_reg >>> i_reg;
        arc   = CZW'(arc_of(5'(i_reg)));
        rnd_x = SATW'(px_reg + PW'(1 <<< 29)) >>> 30;
        rnd_y = SATW'(py_reg + PW'(1 <<< 29)) >>> 30;
    end

    // Sequence the steps
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            C_IDLE: if (start) st_next = C_RUN;
            C_RUN:  if (i_reg == IW'(CORDIC_STEPS - 1)) st_next = C_MUL;
            C_MUL:  st_next = C_FIN;
            C_FIN:  st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
        end
        else begin
            st_reg   <= st_next;
            done_reg <= (st_reg == C_FIN);
        end
    end

    // Datapath: load, rotate, compensate, clamp
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            C_IDLE:
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= z0;
                i_reg <= '0;
            end
            C_RUN:
            begin
                if (!z_reg[CZW-1]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - arc;
                end
                else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + arc;
                end
                i_reg <= i_reg + 1'b1;
            end
            C_MUL:
            begin
                px_reg <= x_reg * GAIN_Q30;
                py_reg <= y_reg * GAIN_Q30;
            end
            C_FIN:
            begin
                rx_reg <= sat32(rnd_x);
                ry_reg <= sat32(rnd_y);
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign rx   = rx_reg;
    assign ry   = ry_reg;

endmodule

// ===== rtl/rigid_body_point_set_rotator.sv =====
// ----------------------------------------------------------------------------
// rigid_body_point_set_rotator
// Point table of a rigid object with position, heading and CORDIC rotation.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request channel (op, coordinates, index, time step, heading).
//   result : one emitted point per stored point on tick or heading set, in
//            index order, last flags the final point of a run.
//   cfg_we/cfg_index/cfg_data : register writes; the user is to write only while idle (not enforced).
// Sequence:
//   add / modify : scale multiply, then store; set position and other codes end in idle.
//   tick : Euler step (products, then position and heading update), then per point
//   memory read, iterative CORDIC unit with its gain multiply, and write-back.
//   The single shared CORDIC unit takes the points one after another.
//   Heading set is the same minus the Euler step.
// Reset: position, heading and point count clear; scales reset to 1.0.
//   The point memories are not cleared; only written entries are used.
// Stall: a point waits in the output register; the write-back of the next
//   point holds until the receiver takes it.
// ----------------------------------------------------------------------------
module rigid_body_point_set_rotator
    import rbpsr_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rbpsr_in_if.sink              item,
    rbpsr_out_if.source           result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCALE = 9'b000000010,
        S_STORE = 9'b000000100,
        S_EULER = 9'b000001000,
        S_STEP  = 9'b000010000,
        S_ROT   = 9'b000100000,
        S_LOAD  = 9'b001000000,
        S_WAIT  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;

    // Registers and object state
    logic [31:0]        scale_h_reg, scale_v_reg;
    logic [31:0]        vel_x_reg, vel_y_reg, spin_reg;
    logic [31:0]        pos_x_reg, pos_y_reg, heading_reg, applied_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      k_reg;

    // Captured request
    logic [2:0]         op_reg;
    logic [31:0]        cx_reg, cy_reg;
    logic               col_reg;
    logic [5:0]         idx_reg;
    logic [19:0]        dt_reg;

    // Products
    logic signed [64:0] px_reg, py_reg;
    logic signed [52:0] ex_reg, ey_reg, ez_reg;

    // Point memories
    logic [63:0]        xy_mem [MAX_POINTS];
    logic               col_mem [MAX_POINTS];
    logic [63:0]        xy_rd_reg;
    logic               col_rd_reg;
    logic               rd_en, xy_we, col_we;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [63:0]        wr_data;

    // Rotator hookup
    logic               cd_start, cd_done;
    logic [31:0]        cd_rx, cd_ry, rot_x_reg, rot_y_reg;
    logic signed [CXW-1:0] fx0, fy0;
    logic signed [CZW-1:0] fz0;
    logic [31:0]        delta, ang;
    logic               fold;

    // Output register
    out_item_t          out_reg;
    logic               out_valid_reg;
    logic               out_free, is_last, mod_ok;

    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
    assign out_free     = !out_valid_reg || result.ready;
    assign is_last      = (CW'(k_reg) + 1'b1 == count_reg);
    assign mod_ok       = (8'(idx_reg) < 8'(count_reg));

    // Fold the heading change into the CORDIC range
    always_comb
    begin
        delta = heading_reg - applied_reg;
        fold  = ($signed(delta) > 32'sh4000_0000) || ($signed(delta) < -32'sh4000_0000);
        ang   = fold ? delta + 32'h8000_0000 : delta;
        fz0   = CZW'($signed(ang));
        fx0   = fold ? -CXW'($signed(xy_rd_reg[63:32])) : CXW'($signed(xy_rd_reg[63:32]));
        fy0   = fold ? -CXW'($signed(xy_rd_reg[31:0]))  : CXW'($signed(xy_rd_reg[31:0]));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid) begin
                    case (item.data.op)
                        OP_ADD, OP_MODIFY: state_next = S_SCALE;
                        OP_TICK:           state_next = S_EULER;
                        OP_SET_HDG:        state_next = S_ROT;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_SCALE: state_next = S_STORE;
            S_STORE: state_next = S_IDLE;
            S_EULER: state_next = S_STEP;
            S_STEP:  state_next = S_ROT;
            S_ROT:   state_next = (count_reg == '0) ? S_IDLE : S_LOAD;
            S_LOAD:  state_next = S_WAIT;
            S_WAIT:  if (cd_done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free) begin
                    state_next = is_last ? S_IDLE : S_LOAD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory access controls
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = k_reg;
        xy_we    = 1'b0;
        col_we   = 1'b0;
        wr_addr  = k_reg;
        wr_data  = {rot_x_reg, rot_y_reg};
        cd_start = (state_reg == S_LOAD);
        case (state_reg)
            S_ROT:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_STORE:
            begin
                if (op_reg == OP_ADD) begin
                    xy_we   = (count_reg < CW'(MAX_POINTS));
                    col_we  = xy_we;
                    wr_addr = count_reg[AW-1:0];
                    if (count_reg == '0) begin
                        wr_data = {cx_reg, cy_reg};
                    end
                    else begin
                        wr_data = {sat32(SATW'(px_reg >>> 16)), sat32(SATW'(py_reg >>> 16))};
                    end
                end
                else begin
                    xy_we   = mod_ok;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = {sat32(SATW'(px_reg >>> 16)), sat32(SATW'(py_reg >>> 16))};
                end
            end
            S_EMIT:
            begin
                xy_we   = out_free;
                rd_en   = out_free && !is_last;
                rd_addr = k_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Point memories, registered read
    always_ff @(posedge clk)
    begin
        if (xy_we) begin
            xy_mem[wr_addr] <= wr_data;
        end
        if (col_we) begin
            col_mem[wr_addr] <= col_reg;
        end
        if (rd_en) begin
            xy_rd_reg  <= xy_mem[rd_addr];
            col_rd_reg <= col_mem[rd_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scale_h_reg <= 32'h0001_0000;
            scale_v_reg <= 32'h0001_0000;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            spin_reg    <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCALE_H:    scale_h_reg <= cfg_data;
                REG_SCALE_V:    scale_v_reg <= cfg_data;
                REG_VELOCITY_X: vel_x_reg   <= cfg_data;
                REG_VELOCITY_Y: vel_y_reg   <= cfg_data;
                REG_SPIN_RATE:  spin_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control and object state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            applied_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            // Drop the held point once taken, unless a new one replaces it
            if (out_valid_reg && result.ready && state_reg != S_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid) begin
                        case (item.data.op)
                            OP_SET_POS:
                            begin
                                pos_x_reg <= item.data.coord_x;
                                pos_y_reg <= item.data.coord_y;
                            end
                            OP_SET_HDG: heading_reg <= item.data.heading_in;
                            default: ;
                        endcase
                    end
                end
                S_STORE:
                begin
                    if (op_reg == OP_ADD && count_reg < CW'(MAX_POINTS)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_STEP:
                begin
                    pos_x_reg   <= pos_x_reg + ex_reg[47:16];
                    pos_y_reg   <= pos_y_reg + ey_reg[47:16];
                    heading_reg <= heading_reg + ez_reg[47:16];
                end
                S_ROT:
                begin
                    k_reg <= '0;
                    if (count_reg == '0) begin
                        applied_reg <= heading_reg;
                    end
                end
                S_EMIT:
                begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 1'b1;
                        if (is_last) begin
                            applied_reg <= heading_reg;
                        end
                    end
                    else if (out_valid_reg && result.ready) begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request capture, products and emitted point payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready) begin
            op_reg  <= item.data.op;
            cx_reg  <= item.data.coord_x;
            cy_reg  <= item.data.coord_y;
            col_reg <= item.data.collidable_in;
            idx_reg <= item.data.point_index;
            dt_reg  <= item.data.time_step;
        end
        if (state_reg == S_SCALE) begin
            px_reg <= $signed(cx_reg) * $signed({1'b0, scale_h_reg});
            py_reg <= $signed(cy_reg) * $signed({1'b0, scale_v_reg});
        end
        if (state_reg == S_EULER) begin
            ex_reg <= $signed(vel_x_reg) * $signed({1'b0, dt_reg});
            ey_reg <= $signed(vel_y_reg) * $signed({1'b0, dt_reg});
            ez_reg <= $signed(spin_reg) * $signed({1'b0, dt_reg});
        end
        if (state_reg == S_WAIT && cd_done) begin
            rot_x_reg <= cd_rx;
            rot_y_reg <= cd_ry;
        end
        if (state_reg == S_EMIT && out_free) begin
            out_reg.out_index      <= 6'(k_reg);
            out_reg.world_x        <= rot_x_reg + pos_x_reg;
            out_reg.world_y        <= rot_y_reg + pos_y_reg;
            out_reg.collidable_out <= col_rd_reg;
            out_reg.heading_out    <= heading_reg;
            out_reg.last           <= is_last;
        end
    end

    rbpsr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .x0    (fx0),
        .y0    (fy0),
        .z0    (fz0),
        .done  (cd_done),
        .rx    (cd_rx),
        .ry    (cd_ry)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cd_done |-> state_reg == S_WAIT)
        else $error("rotation finished outside its wait state");

    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> 8'(result.data.out_index) < 8'(count_reg))
        else $error("emitted point beyond point count");
`endif

endmodule
